[rtl/fe8_pkg.sv]
`timescale 1ns / 1ps
package fe8_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam logic signed [32:0] CORDIC_GAIN_INV = 33'sd652032874;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  localparam logic [2:0] REG_ANGULAR_RATE = 3'd0;
  localparam logic [2:0] REG_RADIUS       = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Z     = 3'd4;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
  } cordic_t;

  function automatic logic signed [31:0] atan_unit(input int step);
    logic signed [31:0] r;
    unique case (step)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10680862;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/fe8_cordic_cell.sv]
`timescale 1ns / 1ps
module fe8_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  fe8_pkg::cordic_t d_in,
  output logic            vld,
  output fe8_pkg::cordic_t d_out
);

  fe8_pkg::cordic_t d_next;
  logic signed [32:0] sx;
  logic signed [32:0] sy;

  always_comb begin
    sx = d_in.x >>> STEP;
    sy = d_in.y >>> STEP;
    d_next = d_in;
    if (!d_in.z[31]) begin
      d_next.x = d_in.x - sy;
      d_next.y = d_in.y + sx;
      d_next.z = d_in.z - fe8_pkg::atan_unit(STEP);
    end else begin
      d_next.x = d_in.x + sy;
      d_next.y = d_in.y - sx;
      d_next.z = d_in.z + fe8_pkg::atan_unit(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

[rtl/fe8_rate_scale.sv]
`timescale 1ns / 1ps
module fe8_rate_scale #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic signed [33:0] b,
  input  logic signed [31:0] rate,
  output logic signed [31:0] result
);

  localparam int PW = ANGLE_BITS + 32;
  localparam logic [65:0] LIM = 66'(1) << (ANGLE_BITS + 31);

  logic [33:0] ub;
  logic [31:0] ur;
  logic [65:0] mag;
  logic [PW-1:0] magc;
  logic [PW-1:0] mag1;
  logic neg1;
  logic neg2;
  logic [PW-1:0] lp;
  logic [63:0] ph;
  logic [31:0] pl;
  logic [64:0] q;
  logic [35:0] mq;
  logic signed [36:0] sv;

  always_comb begin
    ub = b[33] ? (~b[33:0] + 34'd1) : b[33:0];
    ur = rate[31] ? (~rate[31:0] + 32'd1) : rate[31:0];
    mag = 66'(ub) * 66'(ur);
    magc = (mag > LIM) ? LIM[PW-1:0] : mag[PW-1:0];
    lp = PW'(mag1[ANGLE_BITS-1:0]) * PW'(fe8_pkg::TWO_PI_Q29);
    q = 65'(ph) + 65'(pl) + 65'(1 << 28);
    mq = q[64:29];
    sv = neg2 ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag1 <= magc;
      neg1 <= b[33] ^ rate[31];
    end
    if (en[1]) begin
      ph <= 64'(mag1[PW-1:ANGLE_BITS]) * 64'(fe8_pkg::TWO_PI_Q29);
      pl <= lp[PW-1:ANGLE_BITS];
      neg2 <= neg1;
    end
    if (en[2]) begin
      result <= fe8_pkg::sat32(40'(sv));
    end
  end

endmodule

[rtl/figure_eight_trajectory_generator.sv]
`timescale 1ns / 1ps
// Figure-eight reference generator: each time stamp request yields one position and
// velocity result. The datapath is a fully pipelined chain (phase multiply, 18 CORDIC
// cells, product and rate-scaling stages), so one request is accepted every cycle
// while the output is not stalled. Configuration writes are taken at any time but
// must only be issued while no request is in flight.
module figure_eight_trajectory_generator #(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] position_x,
  output logic signed [31:0] position_y,
  output logic signed [31:0] position_z,
  output logic signed [31:0] velocity_x,
  output logic signed [31:0] velocity_y
);

  localparam int NS = fe8_pkg::CORDIC_STEPS + 8;
  localparam int SC = fe8_pkg::CORDIC_STEPS + 1;

  logic signed [31:0] angular_rate;
  logic signed [31:0] radius;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic          v0;
  logic [fe8_pkg::CORDIC_STEPS:1] vc;
  logic [NS-1:SC] vt;

  fe8_pkg::cordic_t cd [fe8_pkg::CORDIC_STEPS+1];
  fe8_pkg::cordic_t cd0;

  logic [63:0] prod;
  logic [31:0] ang;

  logic signed [15:0] cq;
  logic signed [15:0] sq;
  logic signed [34:0] cpre;
  logic signed [34:0] spre;
  logic signed [47:0] rc;
  logic signed [47:0] rs;
  logic signed [31:0] sc;
  logic signed [31:0] dd;
  logic signed [63:0] rsc;
  logic signed [63:0] rd;
  logic signed [31:0] px3;
  logic signed [31:0] px4;
  logic signed [31:0] px5;
  logic signed [31:0] px6;
  logic signed [31:0] px7;
  logic signed [31:0] py4;
  logic signed [31:0] py5;
  logic signed [31:0] py6;
  logic signed [31:0] py7;
  logic signed [33:0] bx3;
  logic signed [33:0] bx4;
  logic signed [33:0] by4;
  logic signed [47:0] rcr;
  logic signed [47:0] rsr;
  logic signed [63:0] rscr;
  logic signed [63:0] rdr;

  function automatic logic signed [15:0] to_q15(input logic signed [34:0] val);
    logic signed [34:0] t;
    logic signed [15:0] r;
    t = (val + 35'sd16384) >>> 15;
    if (t > 35'sd32767) begin
      r = 16'sh7FFF;
    end else if (t < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angular_rate <= 32'sd5215;
      radius <= 32'sd131072;
      origin_x <= 32'sd0;
      origin_y <= 32'sd0;
      origin_z <= 32'sd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fe8_pkg::REG_ANGULAR_RATE: angular_rate <= cfg_data;
        fe8_pkg::REG_RADIUS:       radius <= cfg_data;
        fe8_pkg::REG_ORIGIN_X:     origin_x <= cfg_data;
        fe8_pkg::REG_ORIGIN_Y:     origin_y <= cfg_data;
        fe8_pkg::REG_ORIGIN_Z:     origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage moves forward when it is empty or when the stage after it moves.
  assign en[NS] = out_ready;
  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_en
      assign en[g] = !v[g] || en[g+1];
    end
  endgenerate

  assign v = {vt, vc, v0};
  assign cd[0] = cd0;

  assign in_ready = en[0];
  assign out_valid = v[NS-1];

  always_comb begin
    prod = 64'(time_stamp) * 64'(unsigned'(angular_rate))
           - (angular_rate[31] ? {time_stamp, 32'd0} : 64'd0);
    ang = {prod[16+ANGLE_BITS-1:16], {(32-ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en[0]) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cd0.x <= fe8_pkg::CORDIC_GAIN_INV;
      cd0.y <= 33'sd0;
      cd0.z <= $signed({2'b00, ang[29:0]});
      cd0.quad <= ang[31:30];
    end
  end

  generate
    for (g = 0; g < fe8_pkg::CORDIC_STEPS; g++) begin : g_cell
      fe8_cordic_cell #(.STEP(g)) u_cell (
        .clk(clk),
        .rst(rst),
        .en(en[g+1]),
        .vld_in(v[g]),
        .d_in(cd[g]),
        .vld(vc[g+1]),
        .d_out(cd[g+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= '0;
    end else begin
      for (int i = SC; i < NS; i++) begin
        if (en[i]) begin
          vt[i] <= v[i-1];
        end
      end
    end
  end

  always_comb begin
    unique case (cd[fe8_pkg::CORDIC_STEPS].quad)
      2'd0: begin
        cpre = 35'(cd[fe8_pkg::CORDIC_STEPS].x);
        spre = 35'(cd[fe8_pkg::CORDIC_STEPS].y);
      end
      2'd1: begin
        cpre = -35'(cd[fe8_pkg::CORDIC_STEPS].y);
        spre = 35'(cd[fe8_pkg::CORDIC_STEPS].x);
      end
      2'd2: begin
        cpre = -35'(cd[fe8_pkg::CORDIC_STEPS].x);
        spre = -35'(cd[fe8_pkg::CORDIC_STEPS].y);
      end
      default: begin
        cpre = 35'(cd[fe8_pkg::CORDIC_STEPS].y);
        spre = -35'(cd[fe8_pkg::CORDIC_STEPS].x);
      end
    endcase
    rcr = (rc + 48'sd16384) >>> 15;
    rsr = (rs + 48'sd16384) >>> 15;
    rscr = (rsc + 64'sd268435456) >>> 29;
    rdr = (rd + 64'sd268435456) >>> 29;
  end

  always_ff @(posedge clk) begin
    if (en[SC]) begin
      cq <= to_q15(cpre);
      sq <= to_q15(spre);
    end
    if (en[SC+1]) begin
      rc <= 48'(radius) * 48'(cq);
      rs <= 48'(radius) * 48'(sq);
      sc <= 32'(sq) * 32'(cq);
      dd <= 32'(cq) * 32'(cq) - 32'(sq) * 32'(sq);
    end
    if (en[SC+2]) begin
      px3 <= fe8_pkg::sat32(40'(origin_x) + 40'(rcr));
      bx3 <= -34'(rsr);
      rsc <= 64'(radius) * 64'(sc);
      rd <= 64'(radius) * 64'(dd);
    end
    if (en[SC+3]) begin
      px4 <= px3;
      bx4 <= bx3;
      py4 <= fe8_pkg::sat32(40'(origin_y) + 40'(rscr));
      by4 <= 34'(rdr);
    end
    if (en[SC+4]) begin
      px5 <= px4;
      py5 <= py4;
    end
    if (en[SC+5]) begin
      px6 <= px5;
      py6 <= py5;
    end
    if (en[SC+6]) begin
      px7 <= px6;
      py7 <= py6;
    end
  end

  fe8_rate_scale #(.ANGLE_BITS(ANGLE_BITS)) u_scale_x (
    .clk(clk),
    .en(en[SC+6:SC+4]),
    .b(bx4),
    .rate(angular_rate),
    .result(velocity_x)
  );

  fe8_rate_scale #(.ANGLE_BITS(ANGLE_BITS)) u_scale_y (
    .clk(clk),
    .en(en[SC+6:SC+4]),
    .b(by4),
    .rate(angular_rate),
    .result(velocity_y)
  );

  assign position_x = px7;
  assign position_y = py7;
  assign position_z = origin_z;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> &v) else $error("input blocked while pipeline has a bubble");
  a_ready_passes: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready) else $error("input blocked while output drains");
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result present right after reset");

endmodule

[test/fe8_checker.sv]
`timescale 1ns / 1ps
module fe8_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] time_stamp,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] position_x,
  input  logic [31:0] position_y,
  input  logic [31:0] position_z,
  input  logic [31:0] velocity_x,
  input  logic [31:0] velocity_y,
  output int          fail_count,
  output int          pending
);

  localparam int ABITS = 16;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } point_t;

  logic signed [31:0] rate_q, rad_q, ox_q, oy_q, oz_q;
  point_t expected_points[$];

  longint atan_tbl[18] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void trig(input logic [31:0] phase, output longint c, output longint s);
    logic [31:0] a;
    longint x, y, z, dx, dy, cc, ss;
    a = phase << (32 - ABITS);
    x = 652032874;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < 18; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    case (a[31:30])
      2'd0: begin cc = x; ss = y; end
      2'd1: begin cc = -y; ss = x; end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = round_q15(cc);
    s = round_q15(ss);
  endfunction

  function automatic longint rate_velocity(longint b, longint rate);
    logic neg;
    logic [127:0] mag, lim, q;
    neg = (b < 0) != (rate < 0);
    if (b == 0 || rate == 0) return 0;
    mag = 128'(b < 0 ? -b : b) * 128'(rate < 0 ? -rate : rate);
    lim = 128'd1 << (ABITS + 31);
    if (mag > lim) mag = lim;
    q = (mag >> ABITS) * 128'd3373259426
      + (((mag & ((128'd1 << ABITS) - 1)) * 128'd3373259426) >> ABITS);
    q = (q + (128'd1 << 28)) >> 29;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic point_t predict_point(logic [31:0] t);
    point_t p;
    longint rate, r, c, s, bx, by;
    logic [63:0] prod;
    rate = rate_q;
    r = rad_q;
    prod = 64'(t) * 64'(rate);
    trig(32'(prod[16 +: ABITS]), c, s);
    p.px = 32'(clamp32(longint'(ox_q) + ((r * c + 16384) >>> 15)));
    p.py = 32'(clamp32(longint'(oy_q) + ((r * (s * c) + (64'sd1 <<< 28)) >>> 29)));
    p.pz = oz_q;
    bx = -((r * s + 16384) >>> 15);
    by = (r * (c * c - s * s) + (64'sd1 <<< 28)) >>> 29;
    p.vx = 32'(rate_velocity(bx, rate));
    p.vy = 32'(rate_velocity(by, rate));
    return p;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name,
               $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_t w;
    if (rst) begin
      rate_q <= 32'sd5215;
      rad_q <= 32'sd131072;
      ox_q <= '0;
      oy_q <= '0;
      oz_q <= 32'sd65536;
      expected_points.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fe8_pkg::REG_ANGULAR_RATE: rate_q <= cfg_data;
          fe8_pkg::REG_RADIUS: rad_q <= cfg_data;
          fe8_pkg::REG_ORIGIN_X: ox_q <= cfg_data;
          fe8_pkg::REG_ORIGIN_Y: oy_q <= cfg_data;
          fe8_pkg::REG_ORIGIN_Z: oz_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_points.push_back(predict_point(time_stamp));
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t unexpected result: expected none actual x=%0d", $time,
                   $signed(position_x));
          fail_count++;
        end else begin
          w = expected_points.pop_front();
          compare_field("position_x", w.px, position_x);
          compare_field("position_y", w.py, position_y);
          compare_field("position_z", w.pz, position_z);
          compare_field("velocity_x", w.vx, velocity_x);
          compare_field("velocity_y", w.vy, velocity_y);
        end
      end
    end
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [31:0] time_stamp = '0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] position_x, position_y, position_z, velocity_x, velocity_y;
  int fail_count, pending;
  int cycle_count = 0;
  int stall_mode = 0;

  always #2 clk = ~clk;

  figure_eight_trajectory_generator dut (.*);

  fe8_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("[figure_eight_trajectory_generator] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (cycle_count % 7) < 3;
    endcase
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_stamp(logic [31:0] t);
    time_stamp <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_burst(int n);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (left > 0) begin
          send_stamp($urandom_range(0, 3) == 0 ? $urandom_range(0, 2000000) : $urandom);
          left--;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  logic [31:0] directed_stamps[12] = '{32'h0, 32'hFFFFFFFF, 32'h00010000, 32'h1,
    32'h80000000, 32'h7FFFFFFF, 32'h00004000, 32'h0000C000, 32'h00020000,
    32'h00008000, 32'hAAAAAAAA, 32'h55555555};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_stamps[i]) send_stamp(directed_stamps[i]);
    drain();
    write_reg(fe8_pkg::REG_ANGULAR_RATE, 32'h7FFFFFFF);
    write_reg(fe8_pkg::REG_RADIUS, 32'h7FFFFFFF);
    write_reg(fe8_pkg::REG_ORIGIN_X, 32'h7FFFFFFF);
    write_reg(fe8_pkg::REG_ORIGIN_Y, 32'h80000000);
    write_reg(fe8_pkg::REG_ORIGIN_Z, 32'h80000000);
    write_reg(3'd7, 32'h12345678);
    foreach (directed_stamps[i]) send_stamp(directed_stamps[i]);
    drain();
    write_reg(fe8_pkg::REG_ANGULAR_RATE, 32'h80000000);
    write_reg(fe8_pkg::REG_RADIUS, 32'h80000000);
    foreach (directed_stamps[i]) send_stamp(directed_stamps[i]);
    drain();
    for (int phase_n = 0; phase_n < 7; phase_n++) begin
      write_reg(fe8_pkg::REG_ANGULAR_RATE, pick_word());
      write_reg(fe8_pkg::REG_RADIUS, pick_word());
      write_reg(fe8_pkg::REG_ORIGIN_X, pick_word());
      write_reg(fe8_pkg::REG_ORIGIN_Y, pick_word());
      write_reg(fe8_pkg::REG_ORIGIN_Z, pick_word());
      random_burst(250);
      drain();
    end
    if (fail_count == 0) begin
      $display("[figure_eight_trajectory_generator] OK");
    end else begin
      $display("[figure_eight_trajectory_generator] ERROR");
    end
    $finish;
  end
endmodule
